// File: rtl/core/svf_and_ladder_audio_filter_assert.svh
// Assertion macros for the audio filter.
`ifndef SVF_AND_LADDER_AUDIO_FILTER_ASSERT_SVH
`define SVF_AND_LADDER_AUDIO_FILTER_ASSERT_SVH

`define SVFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`define SVFL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/svfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svfl_pkg;

	localparam int LADDER_STAGES = 4;
	localparam int STAGE_IW = $clog2(LADDER_STAGES);

	localparam logic [21:0] TANH_ONE = 22'h100000;
	localparam logic [24:0] TANH_LIMIT = 25'h300000;
	localparam logic [26:0] TANH_K27 = 27'd28311552;

	localparam logic [1:0] TAP_BAND = 2'd1;
	localparam logic [1:0] TAP_HIGH = 2'd2;

	typedef logic signed [23:0] q420_t;

	typedef enum logic [2:0] {
		REG_FILTER_TYPE,
		REG_RESPONSE_MODE,
		REG_SVF_COEF,
		REG_DAMPING,
		REG_LADDER_COEF,
		REG_RESONANCE
	} reg_index_t;

	typedef struct packed {
		logic        filter_type;
		logic [1:0]  response_mode;
		logic [14:0] svf_coef;
		logic [15:0] damping;
		logic [15:0] ladder_coef;
		logic [14:0] resonance;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_FB,
		OP_LP,
		OP_MUL_QB,
		OP_HI,
		OP_MUL_FH,
		OP_BP,
		OP_SVF_OUT,
		OP_MUL_R,
		OP_U,
		OP_TS_DRV,
		OP_TS_ST,
		OP_WR_DRV,
		OP_WR_A,
		OP_WR_B,
		OP_DIFF,
		OP_MUL_GD,
		OP_ST_UPD,
		OP_LAD_OUT
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [STAGE_IW-1:0] stage;
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_FB,
		ST_S_LP,
		ST_S_QB,
		ST_S_HI,
		ST_S_FH,
		ST_S_BP,
		ST_S_OUT,
		ST_L_MULR,
		ST_L_U,
		ST_L_T0,
		ST_L_T0W,
		ST_L_TA,
		ST_L_TAW,
		ST_L_TB,
		ST_L_TBW,
		ST_L_DIFF,
		ST_L_MULG,
		ST_L_UPD,
		ST_L_OUT
	} ctrl_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_SQUARE,
		T_FRAC,
		T_DIV,
		T_DONE
	} tanh_state_t;

	// Arithmetic shift right by s with rounding to nearest, ties away from zero.
	function automatic logic signed [47:0] rshr(input logic signed [47:0] v,
			input int unsigned s);
		logic signed [47:0] half;
		half = 48'sd1 <<< (s - 1);
		return (v + half - $signed({47'd0, v[47]})) >>> s;
	endfunction

	function automatic q420_t sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -48'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) begin
			return 16'sh7FFF;
		end
		if (v < -48'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/svfl_tanh.sv
`timescale 1ns / 1ps
`default_nettype none
module svfl_tanh
	import svfl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [24:0] operand,
	output logic                    done,
	output logic signed [21:0]      result
);

	tanh_state_t state_q, state_d;

	logic        neg_q, clamp_q;
	logic [21:0] a_q;
	logic [23:0] a2_q;
	logic [26:0] den_q;
	logic [26:0] rem_q;
	logic [21:0] n_q;
	logic [21:0] quo_q;
	logic [4:0]  cnt_q;

	logic [24:0] abs_v;
	logic [43:0] sq;
	logic [44:0] sq_rnd;
	logic [26:0] den_v;
	logic [47:0] num_v;
	logic [47:0] nsum;
	logic [27:0] trial;
	logic        ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done = 1'b0;
		case (state_q)
			T_IDLE: begin
				if (start) begin
					state_d = T_SQUARE;
				end
			end
			T_SQUARE: state_d = T_FRAC;
			T_FRAC: state_d = T_DIV;
			T_DIV: begin
				if (cnt_q == 5'd21) begin
					state_d = T_DONE;
				end
			end
			T_DONE: begin
				done = 1'b1;
				state_d = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		abs_v = operand[24] ? 25'(-operand) : 25'(operand);
		sq = 44'(a_q) * 44'(a_q);
		sq_rnd = 45'(sq) + 45'h80000;
		den_v = TANH_K27 + 27'({a2_q, 3'b000}) + 27'(a2_q);
		num_v = 48'(a_q) * 48'(TANH_K27 + 27'(a2_q));
		nsum = num_v + 48'(den_v[26:1]);
		trial = {rem_q, n_q[21]};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (start) begin
					neg_q <= operand[24];
					clamp_q <= abs_v >= TANH_LIMIT;
					a_q <= abs_v[21:0];
				end
			end
			T_SQUARE: a2_q <= sq_rnd[43:20];
			T_FRAC: begin
				den_q <= den_v;
				rem_q <= {1'b0, nsum[47:22]};
				n_q <= nsum[21:0];
				cnt_q <= 5'd0;
			end
			T_DIV: begin
				rem_q <= ge ? 27'(trial - {1'b0, den_q}) : trial[26:0];
				n_q <= {n_q[20:0], 1'b0};
				quo_q <= {quo_q[20:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (clamp_q) begin
			result = neg_q ? $signed(-TANH_ONE) : $signed(TANH_ONE);
		end else begin
			result = neg_q ? $signed(-quo_q) : $signed(quo_q);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/svfl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module svfl_datapath
	import svfl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire dp_cmd_t            cmd,
	input  wire logic signed [15:0] sample_in,
	output logic                    tanh_done,
	output logic signed [15:0]      sample_out
);

	localparam logic [STAGE_IW-1:0] LAST = STAGE_IW'(LADDER_STAGES - 1);

	q420_t lp_q, bp_q, hi_q;
	q420_t st_q [LADDER_STAGES];
	logic signed [20:0] x_q;
	logic signed [24:0] drv_q;
	logic signed [21:0] ta_q, tb_q;
	logic signed [22:0] d_q;
	logic signed [40:0] prod_q;
	logic signed [15:0] y_q;

	logic signed [40:0] mul_a, mul_b;
	logic               tanh_start;
	logic signed [24:0] tanh_operand;
	logic signed [21:0] tanh_result;
	q420_t              st_new;
	q420_t              tap;

	svfl_tanh u_tanh (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tanh_start),
		.operand (tanh_operand),
		.done    (tanh_done),
		.result  (tanh_result)
	);

	always_comb begin
		mul_a = 41'(bp_q);
		mul_b = 41'($signed({1'b0, cfg.svf_coef}));
		case (cmd.op)
			OP_MUL_QB: mul_b = 41'($signed({1'b0, cfg.damping}));
			OP_MUL_FH: mul_a = 41'(hi_q);
			OP_MUL_R: begin
				mul_a = 41'(st_q[LAST]);
				mul_b = 41'($signed({1'b0, cfg.resonance}));
			end
			OP_MUL_GD: begin
				mul_a = 41'(d_q);
				mul_b = 41'($signed({1'b0, cfg.ladder_coef}));
			end
			default: begin
			end
		endcase
		tanh_start = (cmd.op == OP_TS_DRV) || (cmd.op == OP_TS_ST);
		tanh_operand = (cmd.op == OP_TS_ST) ? 25'(st_q[cmd.stage]) : drv_q;
		st_new = sat24(48'(st_q[cmd.stage]) + rshr(48'(prod_q), 16));
		case (cfg.response_mode)
			TAP_BAND: tap = bp_q;
			TAP_HIGH: tap = hi_q;
			default: tap = lp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			bp_q <= '0;
			for (int i = 0; i < LADDER_STAGES; i++) begin
				st_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				OP_LP: lp_q <= sat24(48'(lp_q) + rshr(48'(prod_q), 14));
				OP_BP: bp_q <= sat24(48'(bp_q) + rshr(48'(prod_q), 14));
				OP_ST_UPD: st_q[cmd.stage] <= st_new;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: x_q <= {sample_in, 5'b00000};
			OP_MUL_FB, OP_MUL_QB, OP_MUL_FH, OP_MUL_R, OP_MUL_GD: prod_q <= mul_a * mul_b;
			OP_HI: hi_q <= sat24(48'(x_q) - 48'(lp_q) - rshr(48'(prod_q), 12));
			OP_SVF_OUT: y_q <= sat16(rshr(48'(tap), 5));
			OP_U: drv_q <= 25'(48'(x_q) - rshr(48'(prod_q), 15));
			OP_WR_DRV: drv_q <= 25'(tanh_result);
			OP_WR_A: ta_q <= tanh_result;
			OP_WR_B: tb_q <= tanh_result;
			OP_DIFF: d_q <= 23'(ta_q) - 23'(tb_q);
			OP_ST_UPD: drv_q <= 25'(st_new);
			OP_LAD_OUT: y_q <= sat16(rshr(48'(st_q[LAST]), 5));
			default: begin
			end
		endcase
	end

	assign sample_out = y_q;

endmodule
`default_nettype wire

// File: rtl/core/svfl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module svfl_ctrl
	import svfl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic filter_type,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire logic tanh_done,
	output dp_cmd_t   cmd
);

	localparam logic [STAGE_IW-1:0] LAST = STAGE_IW'(LADDER_STAGES - 1);

	ctrl_state_t state_q, state_d;
	logic [STAGE_IW-1:0] k_q;
	logic out_valid_q;
	logic load_out, k_inc, k_clr, slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (k_clr) begin
				k_q <= '0;
			end else if (k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.stage = k_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		k_inc = 1'b0;
		k_clr = 1'b0;
		slot_free = !out_valid_q || out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = filter_type ? ST_L_MULR : ST_S_FB;
				end
			end
			ST_S_FB: begin
				cmd.op = OP_MUL_FB;
				state_d = ST_S_LP;
			end
			ST_S_LP: begin
				cmd.op = OP_LP;
				state_d = ST_S_QB;
			end
			ST_S_QB: begin
				cmd.op = OP_MUL_QB;
				state_d = ST_S_HI;
			end
			ST_S_HI: begin
				cmd.op = OP_HI;
				state_d = ST_S_FH;
			end
			ST_S_FH: begin
				cmd.op = OP_MUL_FH;
				state_d = ST_S_BP;
			end
			ST_S_BP: begin
				cmd.op = OP_BP;
				state_d = ST_S_OUT;
			end
			ST_S_OUT: begin
				if (slot_free) begin
					cmd.op = OP_SVF_OUT;
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_L_MULR: begin
				cmd.op = OP_MUL_R;
				state_d = ST_L_U;
			end
			ST_L_U: begin
				cmd.op = OP_U;
				state_d = ST_L_T0;
			end
			ST_L_T0: begin
				cmd.op = OP_TS_DRV;
				state_d = ST_L_T0W;
			end
			ST_L_T0W: begin
				if (tanh_done) begin
					cmd.op = OP_WR_DRV;
					k_clr = 1'b1;
					state_d = ST_L_TA;
				end
			end
			ST_L_TA: begin
				cmd.op = OP_TS_DRV;
				state_d = ST_L_TAW;
			end
			ST_L_TAW: begin
				if (tanh_done) begin
					cmd.op = OP_WR_A;
					state_d = ST_L_TB;
				end
			end
			ST_L_TB: begin
				cmd.op = OP_TS_ST;
				state_d = ST_L_TBW;
			end
			ST_L_TBW: begin
				if (tanh_done) begin
					cmd.op = OP_WR_B;
					state_d = ST_L_DIFF;
				end
			end
			ST_L_DIFF: begin
				cmd.op = OP_DIFF;
				state_d = ST_L_MULG;
			end
			ST_L_MULG: begin
				cmd.op = OP_MUL_GD;
				state_d = ST_L_UPD;
			end
			ST_L_UPD: begin
				cmd.op = OP_ST_UPD;
				if (k_q == LAST) begin
					state_d = ST_L_OUT;
				end else begin
					k_inc = 1'b1;
					state_d = ST_L_TA;
				end
			end
			ST_L_OUT: begin
				if (slot_free) begin
					cmd.op = OP_LAD_OUT;
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/svf_and_ladder_audio_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Mono audio filter: one Q1.15 sample in, one saturated Q1.15 sample out per transaction.
// The filter_type register selects a Chamberlin state-variable filter (lowpass, bandpass or
// highpass tap) or a four-stage ladder with resonance feedback and rational tanh saturation.
// One sample is processed at a time. The ladder runs nine tanh evaluations in one shared unit
// whose divider yields one quotient bit per cycle. The finished sample waits in an output
// register, so the next input is taken while the result is still pending. Registers are
// written over the APB port at byte address 4*i and should be changed only while idle.
`include "svf_and_ladder_audio_filter_assert.svh"
module svf_and_ladder_audio_filter
	import svfl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic signed [15:0] sample_in,
	input  wire logic               sample_in_valid,
	output logic                    sample_in_ready,
	output logic signed [15:0]      sample_out,
	output logic                    sample_out_valid,
	input  wire logic               sample_out_ready
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	logic    tanh_done;
	logic    wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_type <= 1'b0;
			cfg_q.response_mode <= 2'd0;
			cfg_q.svf_coef <= 15'd2143;
			cfg_q.damping <= 16'd8176;
			cfg_q.ladder_coef <= 16'd4289;
			cfg_q.resonance <= 15'd16384;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_FILTER_TYPE: cfg_q.filter_type <= pwdata[0];
				REG_RESPONSE_MODE: cfg_q.response_mode <= pwdata[1:0];
				REG_SVF_COEF: cfg_q.svf_coef <= pwdata[14:0];
				REG_DAMPING: cfg_q.damping <= pwdata[15:0];
				REG_LADDER_COEF: cfg_q.ladder_coef <= pwdata[15:0];
				REG_RESONANCE: cfg_q.resonance <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[4:2])
				REG_FILTER_TYPE: prdata = 32'(cfg_q.filter_type);
				REG_RESPONSE_MODE: prdata = 32'(cfg_q.response_mode);
				REG_SVF_COEF: prdata = 32'(cfg_q.svf_coef);
				REG_DAMPING: prdata = 32'(cfg_q.damping);
				REG_LADDER_COEF: prdata = 32'(cfg_q.ladder_coef);
				REG_RESONANCE: prdata = 32'(cfg_q.resonance);
				default: prdata = '0;
			endcase
		end
	end

	svfl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.filter_type (cfg_q.filter_type),
		.in_valid    (sample_in_valid),
		.in_ready    (sample_in_ready),
		.out_valid   (sample_out_valid),
		.out_ready   (sample_out_ready),
		.tanh_done   (tanh_done),
		.cmd         (cmd)
	);

	svfl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.tanh_done  (tanh_done),
		.sample_out (sample_out)
	);

	`SVFL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sample_in_valid && sample_in_ready, !sample_in_ready, "input accepted while a sample is in progress")
	`SVFL_ASSERT_NEXT(a_no_spurious_out, clk, arst_n, sample_out_valid && sample_out_ready && sample_in_ready, !sample_out_valid, "result appeared without a finished sample")
	`SVFL_ASSERT_SAME(a_out_ends_work, clk, arst_n, $rose(sample_out_valid), sample_in_ready, "result posted while the sequencer is still busy")

endmodule
`default_nettype wire
